// ===== hdl/feedback_delay_accumulator_defines.svh =====
// Assertion macros for the feedback delay accumulator.
// Each macro takes a label, the clock, the synchronous reset and the
// expression to check; the check is skipped while reset is high.
`ifndef FEEDBACK_DELAY_ACCUMULATOR_DEFINES_SVH
`define FEEDBACK_DELAY_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define FDA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fda: assertion failed");

`define FDA_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("fda: forbidden condition seen");

`else

`define FDA_ASSERT(label, clk, rst, prop)

`define FDA_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== hdl/fda_pkg.sv =====
package fda_pkg;

   // slot store geometry
   localparam int DEPTH    = 1024;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int LEN_W    = ADDR_W + 1;

   // field widths
   localparam int SAMPLE_W   = 16;
   localparam int SLOT_W     = 24;
   localparam int GAIN_W     = 16;
   localparam int OFF_W      = 10;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = ((SAMPLE_W + OFF_W + 7) / 8) * 8;

   // Q1.15 gain arithmetic
   localparam int FRAC_W     = 15;
   localparam int PROD_W     = SLOT_W + GAIN_W;
   localparam int SCALED_W   = PROD_W - FRAC_W;
   localparam int WIDE_W     = SCALED_W + 1;
   localparam int ROUND_HALF = 1 << (FRAC_W - 1);

   // register reset values
   localparam int LEN_RESET  = 10;
   localparam int GAIN_RESET = 16384;

   // register indexes
   localparam logic CSR_DELAY_LENGTH  = 1'b0;
   localparam logic CSR_FEEDBACK_GAIN = 1'b1;

   // item kinds
   localparam logic MODE_PROCESS = 1'b0;
   localparam logic MODE_DRAIN   = 1'b1;

   // work queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                       mode;
      logic signed [SAMPLE_W-1:0] sample;
      logic [ADDR_W-1:0]          pos;
      logic [ADDR_W-1:0]          tgt;
   } fda_work_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain;
   } fda_cfg_type;

   typedef struct packed {
      logic clear_done;
   } fda_status_type;

endpackage

// ===== hdl/fda_front.sv =====
module fda_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fda_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [fda_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  fda_pkg::fda_status_type         status,
   output fda_pkg::fda_cfg_type            cfg,
   output logic                            push_valid,
   input  logic                            push_ready,
   output fda_pkg::fda_work_type           push_data
);
   import fda_pkg::*;

   logic [LEN_W-1:0]         len_raw_ff, len_raw_in;
   logic signed [GAIN_W-1:0] gain_ff, gain_in;
   logic [ADDR_W-1:0]        pos_ff, pos_in;

   logic [LEN_W-1:0]  len;
   logic [ADDR_W-1:0] cur_pos;
   logic [LEN_W-1:0]  off;
   logic [LEN_W-1:0]  tgt_sum;
   logic [LEN_W-1:0]  tgt_wrap;
   logic [LEN_W-1:0]  pos_inc;
   logic              accept;

   always_comb begin
      len_raw_in = len_raw_ff;
      gain_in    = gain_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DELAY_LENGTH:  len_raw_in = csr_wdata[LEN_W-1:0];
            CSR_FEEDBACK_GAIN: gain_in    = csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // zero acts as one slot, anything above the store size as the full store
   always_comb begin
      if (len_raw_ff == '0) begin
         len = LEN_W'(1);
      end else if (len_raw_ff > LEN_W'(DEPTH)) begin
         len = LEN_W'(DEPTH);
      end else begin
         len = len_raw_ff;
      end
   end

   always_comb begin
      cur_pos = (LEN_W'(pos_ff) >= len) ? '0 : pos_ff;
      off     = LEN_W'(req_tdata[SAMPLE_W +: OFF_W]);
      if (off >= len) begin
         off = len - LEN_W'(1);
      end
      tgt_sum  = LEN_W'(cur_pos) + off;
      tgt_wrap = (tgt_sum >= len) ? tgt_sum - len : tgt_sum;
      pos_inc  = LEN_W'(cur_pos) + LEN_W'(1);
   end

   assign req_tready = push_ready && status.clear_done;
   assign push_valid = req_tvalid && status.clear_done;
   assign accept     = req_tvalid && req_tready;

   assign push_data.mode   = req_tuser;
   assign push_data.sample = req_tdata[SAMPLE_W-1:0];
   assign push_data.pos    = cur_pos;
   assign push_data.tgt    = tgt_wrap[ADDR_W-1:0];

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = (pos_inc >= len) ? '0 : pos_inc[ADDR_W-1:0];
      end
   end

   assign cfg.gain = gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_raw_ff <= LEN_W'(LEN_RESET);
         gain_ff    <= GAIN_W'(GAIN_RESET);
         pos_ff     <= '0;
      end else begin
         len_raw_ff <= len_raw_in;
         gain_ff    <= gain_in;
         pos_ff     <= pos_in;
      end
   end

endmodule

// ===== hdl/fda_queue.sv =====
module fda_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  fda_pkg::fda_work_type push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output fda_pkg::fda_work_type pop_data
);
   import fda_pkg::*;

   fda_work_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push;
   logic              pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/fda_back.sv =====
module fda_back (
   input  logic                          clock,
   input  logic                          reset,
   input  fda_pkg::fda_cfg_type          cfg,
   output fda_pkg::fda_status_type       status,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  fda_pkg::fda_work_type         pop_data,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [fda_pkg::SAMPLE_W-1:0]  rsp_tdata
);
   import fda_pkg::*;
   `include "feedback_delay_accumulator_defines.svh"

   localparam int OUT_DEPTH = 2;
   localparam int OPTR_W    = $clog2(OUT_DEPTH);
   localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic                       mode;
      logic signed [SAMPLE_W-1:0] sample;
      logic [ADDR_W-1:0]          pos;
      logic                       same;
      logic signed [PROD_W-1:0]   prod;
   } c_stage_type;

   function automatic logic [SLOT_W-1:0] sat_slot(input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-SLOT_W:0] hi_bits;
      hi_bits = v[WIDE_W-1:SLOT_W-1];
      if ((&hi_bits) || !(|hi_bits)) begin
         return v[SLOT_W-1:0];
      end else if (v[WIDE_W-1]) begin
         return {1'b1, {(SLOT_W-1){1'b0}}};
      end else begin
         return {1'b0, {(SLOT_W-1){1'b1}}};
      end
   endfunction

   function automatic logic [SAMPLE_W-1:0] sat_sample(input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-SAMPLE_W:0] hi_bits;
      hi_bits = v[WIDE_W-1:SAMPLE_W-1];
      if ((&hi_bits) || !(|hi_bits)) begin
         return v[SAMPLE_W-1:0];
      end else if (v[WIDE_W-1]) begin
         return {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   endfunction

   // slot store, two read ports with registered data, one write port
   logic signed [SLOT_W-1:0] slot_mem_ff [DEPTH];
   logic signed [SLOT_W-1:0] rd0_ff, rd1_ff;
   logic                     byp0_ff, byp1_ff;
   logic signed [SLOT_W-1:0] wbyp_ff;

   logic                     we;
   logic [ADDR_W-1:0]        waddr;
   logic signed [SLOT_W-1:0] wdata;
   logic [ADDR_W-1:0]        raddr0, raddr1;

   logic [LEN_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic             clear_done;

   logic         b_valid_ff, b_valid_in;
   fda_work_type b_ff;
   logic         c_valid_ff, c_valid_in;
   c_stage_type  c_ff, c_in;

   logic [SAMPLE_W-1:0] out_entry_ff [OUT_DEPTH];
   logic [OPTR_W-1:0]   out_wr_ff, out_wr_in;
   logic [OPTR_W-1:0]   out_rd_ff, out_rd_in;
   logic [OCNT_W-1:0]   out_cnt_ff, out_cnt_in;
   logic                out_push;
   logic                out_pop;

   logic                     issue;
   logic [OCNT_W-1:0]        pending;
   logic signed [SLOT_W-1:0] echo, old_tgt;
   logic signed [GAIN_W-1:0] gain;
   logic signed [SAMPLE_W-1:0] b_sample, c_sample;
   logic signed [WIDE_W-1:0] tgt_sum;
   logic                     b_wr;
   logic signed [PROD_W-1:0] c_prod, rnd;
   logic signed [SCALED_W-1:0] scaled;
   logic signed [WIDE_W-1:0] out_sum;
   logic [SAMPLE_W-1:0]      c_result;
   logic signed [SLOT_W-1:0] c_wdata;

   // clearing pass after reset
   assign clear_done        = clr_cnt_ff == LEN_W'(DEPTH);
   assign clr_cnt_in        = clear_done ? clr_cnt_ff : clr_cnt_ff + LEN_W'(1);
   assign status.clear_done = clear_done;

   // no new item while stage B holds one; hold off while results could not be stored
   assign pending   = OCNT_W'(c_valid_ff) + out_cnt_ff;
   assign issue     = pop_valid && clear_done && !b_valid_ff &&
                      (pending < OCNT_W'(OUT_DEPTH));
   assign pop_ready = issue;
   assign raddr0    = pop_data.pos;
   assign raddr1    = pop_data.tgt;

   // stage B: echo and target slot are back, form product and target add
   assign echo     = byp0_ff ? wbyp_ff : rd0_ff;
   assign old_tgt  = byp1_ff ? wbyp_ff : rd1_ff;
   assign gain     = cfg.gain;
   assign b_sample = b_ff.sample;
   assign tgt_sum  = WIDE_W'(old_tgt) + WIDE_W'(b_sample);
   assign b_wr     = b_valid_ff && (b_ff.mode == MODE_PROCESS) && (b_ff.tgt != b_ff.pos);

   always_comb begin
      c_in.mode   = b_ff.mode;
      c_in.sample = b_ff.sample;
      c_in.pos    = b_ff.pos;
      c_in.same   = b_ff.tgt == b_ff.pos;
      c_in.prod   = PROD_W'(echo) * PROD_W'(gain);
   end

   // stage C: round the scaled echo, form result and current slot value
   assign c_prod   = c_ff.prod;
   assign c_sample = c_ff.sample;
   assign rnd      = c_prod + PROD_W'(ROUND_HALF);
   assign scaled   = rnd[PROD_W-1:FRAC_W];
   assign out_sum  = WIDE_W'(scaled) + WIDE_W'(c_sample);

   always_comb begin
      if (c_ff.mode == MODE_DRAIN) begin
         c_result = sat_sample(WIDE_W'(scaled));
         c_wdata  = '0;
      end else begin
         c_result = sat_sample(out_sum);
         c_wdata  = c_ff.same ? sat_slot(out_sum) : sat_slot(WIDE_W'(scaled));
      end
   end

   // write port: stages B and C never coincide, clearing runs alone
   always_comb begin
      if (c_valid_ff) begin
         we    = 1'b1;
         waddr = c_ff.pos;
         wdata = c_wdata;
      end else if (b_wr) begin
         we    = 1'b1;
         waddr = b_ff.tgt;
         wdata = sat_slot(tgt_sum);
      end else begin
         we    = !clear_done;
         waddr = clr_cnt_ff[ADDR_W-1:0];
         wdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         slot_mem_ff[waddr] <= wdata;
      end
      rd0_ff  <= slot_mem_ff[raddr0];
      rd1_ff  <= slot_mem_ff[raddr1];
      byp0_ff <= we && (waddr == raddr0);
      byp1_ff <= we && (waddr == raddr1);
      wbyp_ff <= wdata;
   end

   assign b_valid_in = issue;
   assign c_valid_in = b_valid_ff;

   always_ff @(posedge clock) begin
      if (issue) begin
         b_ff <= pop_data;
      end
      if (b_valid_ff) begin
         c_ff <= c_in;
      end
   end

   // result buffer
   assign out_push   = c_valid_ff;
   assign rsp_tvalid = out_cnt_ff != '0;
   assign rsp_tdata  = out_entry_ff[out_rd_ff];
   assign out_pop    = rsp_tvalid && rsp_tready;

   always_comb begin
      out_wr_in  = out_wr_ff;
      out_rd_in  = out_rd_ff;
      out_cnt_in = out_cnt_ff;
      if (out_push) begin
         out_wr_in = (out_wr_ff == OPTR_W'(OUT_DEPTH - 1)) ? '0 : out_wr_ff + OPTR_W'(1);
      end
      if (out_pop) begin
         out_rd_in = (out_rd_ff == OPTR_W'(OUT_DEPTH - 1)) ? '0 : out_rd_ff + OPTR_W'(1);
      end
      if (out_push && !out_pop) begin
         out_cnt_in = out_cnt_ff + OCNT_W'(1);
      end else if (out_pop && !out_push) begin
         out_cnt_in = out_cnt_ff - OCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_entry_ff[out_wr_ff] <= c_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         out_wr_ff  <= out_wr_in;
         out_rd_ff  <= out_rd_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   `FDA_ASSERT_NEVER(a_stages_overlap, clock, reset, b_valid_ff && c_valid_ff)
   `FDA_ASSERT(a_b_to_c, clock, reset, b_valid_ff |=> c_valid_ff)
   `FDA_ASSERT(a_no_work_while_clearing, clock, reset, !clear_done |-> (!b_valid_ff && !c_valid_ff))
   `FDA_ASSERT_NEVER(a_out_overflow, clock, reset, out_push && !out_pop && (out_cnt_ff == OCNT_W'(OUT_DEPTH)))

endmodule

// ===== hdl/feedback_delay_accumulator.sv =====
// Feedback echo on a ring of accumulating slots.
// Input channel req_*: one item per sample; req_tuser selects process (0) or
// drain (1), req_tdata carries the sample and the tap offset. Each item gives
// exactly one result on rsp_*: the sample plus the gain-scaled echo,
// saturated to 16 bits (drain items give the scaled echo alone).
// Configuration: csr_we writes csr_wdata to register csr_index at the clock edge
// (0 delay_length, 1 feedback_gain); the user writes only while no item is in flight,
// the block does not enforce it. The back end takes no new item while the previous one
// is in stage B; a process item with target and position apart writes the slot memory
// twice, other items once; the memory has a single write port. An accepted item passes
// the work queue, stages B and C, result buffer; it waits while the back end is busy.
// Reset: synchronous; registers return to length 10 and gain 0.5, then a
// clearing pass zeroes the 1024 slots with req_tready low.
// Stall: a stalled receiver leaves up to two results buffered and two items
// queued; after that req_tready drops until results are taken.
module feedback_delay_accumulator (
   input  logic                            clock,
   input  logic                            reset,
   // input items
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [fda_pkg::REQ_DATA_W-1:0]  req_tdata,  // sample_in[15:0], tap_offset[25:16]
   input  logic                            req_tuser,  // mode
   // result items
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [fda_pkg::SAMPLE_W-1:0]    rsp_tdata,  // sample_out[15:0]
   // configuration
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [fda_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fda_pkg::*;

   fda_status_type status;
   fda_cfg_type    cfg;
   logic           push_valid, push_ready;
   fda_work_type   push_data;
   logic           pop_valid, pop_ready;
   fda_work_type   pop_data;

   // front: registers, ring position, slot addresses for each item
   fda_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .status     (status),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // short work queue decouples acceptance from the memory sequence
   fda_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: slot memory, gain multiply, saturation, result buffer
   fda_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .status     (status),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
